### rtl/twa_pkg.sv
package twa_pkg;

	// window length in samples
	localparam int WINDOW = 41 * 24;

	// sample and mean width, fixed point 10.6
	localparam int SAMPLE_W = 16;

	// ring slot index and sample count (count reaches WINDOW itself)
	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);

	// running sum never overflows: WINDOW samples of SAMPLE_W bits
	localparam int SUM_W = SAMPLE_W + CNT_W;

	// divider step counter
	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_START,
		ST_WAIT,
		ST_OUT
	} twa_state_t;

endpackage

### rtl/twa_div.sv
module twa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [twa_pkg::SUM_W-1:0]      dividend,
	input  logic [twa_pkg::CNT_W-1:0]      divisor,
	output logic                           done,
	output logic [twa_pkg::SUM_W-1:0]      quotient
);

	// restoring division, one quotient bit per cycle, msb first
	logic                           busy_q;
	logic                           done_q;
	logic [twa_pkg::STEP_W-1:0]     step_q;
	logic [twa_pkg::SUM_W-1:0]      quo_q;
	logic [twa_pkg::CNT_W-1:0]      rem_q;
	logic [twa_pkg::CNT_W-1:0]      dvs_q;

	logic [twa_pkg::CNT_W:0]        trial;
	logic [twa_pkg::CNT_W+1:0]      diff;
	logic                           ge;
	logic [twa_pkg::CNT_W-1:0]      rem_d;

	always_comb begin
		trial = {rem_q, quo_q[twa_pkg::SUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		ge    = !diff[twa_pkg::CNT_W+1];
		// remainder stays below the divisor, so it fits the divisor width
		rem_d = ge ? diff[twa_pkg::CNT_W-1:0] : trial[twa_pkg::CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= twa_pkg::STEP_W'(twa_pkg::SUM_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[twa_pkg::SUM_W-2:0], ge};
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/trailing_window_average.sv
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------
// input    | in_valid / in_ready   | sample[15:0]
// output   | out_valid / out_ready | average[15:0], window_full
//
// each sample passes these steps in order: transfer, subtract oldest, add newest,
// divider start, the bit-serial division, seeing done and the load of the
// output register; no new sample is taken until its result is loaded
// reset clears sum, count, ring position and handshake state; ring entries are
// not cleared, an entry is only read back once the whole window is written
// a waiting result blocks input only when a second result is ready to load
module trailing_window_average (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] average,
	output logic        window_full
);

	twa_pkg::twa_state_t state_q, state_d;

	// ring store of the window
	logic [twa_pkg::SAMPLE_W-1:0] ring_mem [twa_pkg::WINDOW];

	logic [twa_pkg::SAMPLE_W-1:0] sample_q;
	logic [twa_pkg::SAMPLE_W-1:0] oldest_q;
	logic [twa_pkg::SUM_W-1:0]    sum_q;
	logic [twa_pkg::CNT_W-1:0]    count_q;
	logic [twa_pkg::PTR_W-1:0]    pos_q;

	logic                         out_valid_q;
	logic [twa_pkg::SAMPLE_W-1:0] average_q;
	logic                         full_out_q;

	logic                         in_xfer;
	logic                         full;
	logic                         div_start;
	logic                         div_done;
	logic [twa_pkg::SUM_W-1:0]    div_quo;
	logic                         out_load;

	assign in_xfer = in_valid && in_ready;
	// count saturates at the window length
	assign full    = (count_q == twa_pkg::CNT_W'(twa_pkg::WINDOW));

	// next state and control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			twa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = twa_pkg::ST_SUB;
				end
			end
			twa_pkg::ST_SUB: begin
				state_d = twa_pkg::ST_ADD;
			end
			twa_pkg::ST_ADD: begin
				state_d = twa_pkg::ST_START;
			end
			twa_pkg::ST_START: begin
				div_start = 1'b1;
				state_d   = twa_pkg::ST_WAIT;
			end
			twa_pkg::ST_WAIT: begin
				if (div_done) begin
					state_d = twa_pkg::ST_OUT;
				end
			end
			twa_pkg::ST_OUT: begin
				// hold the quotient until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = twa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = twa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				twa_pkg::ST_SUB: begin
					// oldest sample leaves only once the window is full
					if (full) begin
						sum_q <= sum_q - twa_pkg::SUM_W'(oldest_q);
					end
				end
				twa_pkg::ST_ADD: begin
					sum_q <= sum_q + twa_pkg::SUM_W'(sample_q);
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
					if (pos_q == twa_pkg::PTR_W'(twa_pkg::WINDOW - 1)) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// sample capture and ring read at the input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample;
			oldest_q <= ring_mem[pos_q];
		end
	end

	// ring write of the new sample
	always_ff @(posedge clk) begin
		if (state_q == twa_pkg::ST_ADD) begin
			ring_mem[pos_q] <= sample_q;
		end
	end

	// bit-serial mean: sum over count, count is at least one here
	twa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			// mean of 16-bit samples always fits in 16 bits
			average_q  <= div_quo[twa_pkg::SAMPLE_W-1:0];
			full_out_q <= full;
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = average_q;
	assign window_full = full_out_q;

endmodule

### tb/sv/trailing_window_average_checker.sv
`timescale 1ns / 1ps

module trailing_window_average_checker
	import twa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] sample,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] average,
	input  logic        window_full,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic                full;
	} window_mean_t;

	// results in flight: one inside the block, one in its output register
	localparam int EXP_DEPTH = 4;

	// own copy of the window
	logic [SAMPLE_W-1:0] ring_hist [WINDOW];
	logic [SUM_W-1:0]    hist_sum;
	logic [CNT_W-1:0]    hist_count;
	logic [PTR_W-1:0]    hist_slot;

	// expected results in transfer order
	window_mean_t expected_means [EXP_DEPTH];
	logic [1:0]   exp_head;
	logic [1:0]   exp_tail;
	int           exp_count;

	// add one sample to the window, drop the oldest once full, give the mean
	function automatic window_mean_t fold_sample(input logic [SAMPLE_W-1:0] s);
		window_mean_t     r;
		logic [SUM_W-1:0] quot;
		if (hist_count == CNT_W'(WINDOW)) begin
			hist_sum = hist_sum - SUM_W'(ring_hist[hist_slot]);
		end else begin
			hist_count = hist_count + 1'b1;
		end
		ring_hist[hist_slot] = s;
		hist_sum = hist_sum + SUM_W'(s);
		hist_slot = (hist_slot == PTR_W'(WINDOW - 1)) ? '0 : hist_slot + 1'b1;
		quot = hist_sum / SUM_W'(hist_count);
		r.mean = quot[SAMPLE_W-1:0];
		r.full = (hist_count == CNT_W'(WINDOW));
		return r;
	endfunction

	task automatic note_mismatch(input string what, input window_mean_t want);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s: want avg %h full %b, got avg %h full %b",
				$time, what, want.mean, want.full, average, window_full);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_mean_t want;
		window_mean_t next_mean;
		if (!arst_n) begin
			hist_sum = '0;
			hist_count = '0;
			hist_slot = '0;
			exp_head = '0;
			exp_tail = '0;
			exp_count = 0;
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (exp_count == 0) begin
					note_mismatch("result transfer with nothing pending", '0);
				end else begin
					want = expected_means[exp_head];
					exp_head = exp_head + 1'b1;
					exp_count--;
					if (want.mean !== average || want.full !== window_full) begin
						note_mismatch("mean mismatch", want);
					end
				end
			end
			if (in_valid && in_ready) begin
				next_mean = fold_sample(sample);
				if (exp_count == EXP_DEPTH) begin
					note_mismatch("input transfer with too many results pending", next_mean);
				end else begin
					expected_means[exp_tail] = next_mean;
					exp_tail = exp_tail + 1'b1;
					exp_count++;
				end
			end
		end
		pending = exp_count;
	end

endmodule

### tb/sv/trailing_window_average_test.sv
`timescale 1ns / 1ps

module trailing_window_average_test;

	import twa_pkg::*;

	localparam int     CLK_HALF     = 6;
	localparam int     RESET_CYCLES = 8;
	// long receiver hold-off, well past the time to fill the output register
	localparam int     HOLD_CYCLES  = 600;
	// extra settling time after the last result
	localparam int     DRAIN_CYCLES = 80;
	localparam int     SPREAD_ITEMS = 700;
	localparam int     TAIL_ITEMS   = 150;
	localparam int     CORNER_ITEMS = 20;
	localparam longint RUN_LIMIT_NS = 6_000_000;

	// idling pattern of the two channels
	typedef enum logic [1:0] {
		PACE_STEADY,
		PACE_SLOW_SOURCE,
		PACE_SLOW_SINK,
		PACE_SLOW_BOTH
	} pace_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] sample;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] average;
	logic        window_full;

	int    errors;
	int    pending;
	int    sent;
	pace_t pace;
	logic  hold_req;

	trailing_window_average dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.average    (average),
		.window_full(window_full)
	);

	// prediction and comparison live in the checker; it watches both channels
	trailing_window_average_checker mean_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.average    (average),
		.window_full(window_full),
		.errors     (errors),
		.pending    (pending)
	);

	always #(CLK_HALF) clk = ~clk;

	// sender idles with a 70 percent chance when slow alone, 21 percent when both are slow
	function automatic bit source_gap();
		case (pace)
			PACE_SLOW_SOURCE: return $urandom_range(99) < 70;
			PACE_SLOW_BOTH: return $urandom_range(99) < 21;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic sink_ready();
		case (pace)
			PACE_SLOW_SINK: return $urandom_range(99) >= 70;
			PACE_SLOW_BOTH: return $urandom_range(99) >= 21;
			default: return 1'b1;
		endcase
	endfunction

	// field extremes, bit patterns and the 10.6 unit values, all during warm-up;
	// the first one makes the divisor 1
	function automatic logic [15:0] corner_sample(input int i);
		case (i)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			4: return 16'h0000;
			5: return 16'h5555;
			6: return 16'hAAAA;
			7: return 16'h8000;
			8: return 16'h7FFF;
			9: return 16'h0040;
			10: return 16'h003F;
			11: return 16'hFFC0;
			12: return 16'h0003;
			13: return 16'hFFFE;
			14: return 16'h0001;
			15: return 16'hFF00;
			16: return 16'h00FF;
			17: return 16'h1234;
			18: return 16'hFFFF;
			default: return 16'h0000;
		endcase
	endfunction

	// random samples leaning on zero, full scale and both ends of the range
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(127));
			3: return 16'hFF80 | 16'($urandom_range(127));
			default: return 16'($urandom);
		endcase
	endfunction

	// one input transfer; valid stays high across back-to-back items
	task automatic offer(input logic [15:0] v);
		while (source_gap()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (!in_ready);
		// switch the idling pattern every hundred transfers
		sent++;
		pace = pace_t'((sent / 100) % 4);
		// one long receiver hold-off while the sender keeps offering
		if (sent == 400) begin
			hold_req = 1'b1;
		end
		@(negedge clk);
	endtask

	// receiver side: ready drawn each cycle, or held low for a long stretch
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= sink_ready();
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		hold_req = 1'b0;
		pace = PACE_STEADY;
		sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < CORNER_ITEMS; i++) begin
			offer(corner_sample(i));
		end
		// warm-up with random content
		repeat (SPREAD_ITEMS) begin
			offer(pick_sample());
		end
		// full scale for a whole window: fills it, wraps the ring, pushes the
		// sum to its largest value and the mean to full scale
		repeat (WINDOW + 4) begin
			offer(16'hFFFF);
		end
		// full window with random content, oldest entries leaving every transfer
		repeat (TAIL_ITEMS) begin
			offer(pick_sample());
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("trailing_window_average_test: clean");
		end else begin
			$display("trailing_window_average_test: errors");
		end
		$finish;
	end

	// hang guard
	initial begin
		#(RUN_LIMIT_NS);
		$display("trailing_window_average_test: errors");
		$finish;
	end

endmodule
